/* rtl/aics_pkg.sv */
`default_nettype none
package aics_pkg;

  localparam int unsigned ModeW = 3;
  localparam int unsigned CountOutW = 7;

  localparam logic [ModeW-1:0] MODE_CLEAR = 3'd0;
  localparam logic [ModeW-1:0] MODE_ADD   = 3'd1;
  localparam logic [ModeW-1:0] MODE_RANGE = 3'd2;
  localparam logic [ModeW-1:0] MODE_ANGLE = 3'd3;
  localparam logic [ModeW-1:0] MODE_FULL  = 3'd4;

endpackage
`default_nettype wire

/* rtl/aics_mem.sv */
`default_nettype none
module aics_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

/* rtl/angular_interval_coverage_set.sv */
// Channel   | Direction | Handshake          | Payload
// command   | in        | start / busy       | mode_i, start_angle_i, end_angle_i
// result    | out       | done_o (strobe)    | visible_o, full_res_o, overflow_o,
//           |           |                    | entry_count_o
// config    | in        | cfg_we_i           | cfg_wdata_i
//
// The table lives in one memory with a registered read; each entry visit reads the entry, then acts on it.
// A query visits each stored entry in turn, and an add works through containment, compaction,
// merge scan and shift as far as each piece needs, twice for a wrap, and then finishes. Clear
// and full queries go straight to the finish step. The result beat lasts one cycle and cannot
// be stalled; busy drops in the cycle the result is shown.
// Reset empties the table.
`default_nettype none
module angular_interval_coverage_set #(
  parameter int unsigned MAX_INTERVALS = 64,
  parameter int unsigned ANGLE_BITS    = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [aics_pkg::ModeW-1:0]    mode_i,
  input  wire logic [ANGLE_BITS-1:0]         start_angle_i,
  input  wire logic [ANGLE_BITS-1:0]         end_angle_i,
  output logic                               done_o,
  output logic                               visible_o,
  output logic                               full_res_o,
  output logic                               overflow_o,
  output logic [aics_pkg::CountOutW-1:0]     entry_count_o,
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_wdata_i
);

  localparam int unsigned AB = ANGLE_BITS;
  localparam int unsigned CW = $clog2(MAX_INTERVALS + 1);
  localparam int unsigned AW = $clog2(MAX_INTERVALS);
  localparam logic [AB-1:0] AMAX = {AB{1'b1}};
  localparam logic [CW-1:0] CMAX = CW'(MAX_INTERVALS);
  localparam logic [CW-1:0] ONE = CW'(1);

  typedef enum logic [3:0] {
    S_IDLE, S_PIECE, S_CONT, S_SWAL, S_MRG, S_NXT, S_DROP, S_SHUP, S_NEXT, S_QRY, S_FIN
  } state_e;

  state_e                 state_q, state_d;
  logic                   ph_q, ph_d;
  logic [CW-1:0]          idx_q, idx_d, wr_q, wr_d, count_q, count_d, spot_q, spot_d;
  logic                   cd_q;
  logic [aics_pkg::ModeW-1:0] mode_q, mode_d;
  logic [AB-1:0]          pa_q, pa_d, pb_q, pb_d, bsave_q, bsave_d, es_q, es_d;
  logic                   pend_q, pend_d, wrap_q, wrap_d, have_q, have_d;
  logic                   cov1_q, cov1_d, cov2_q, cov2_d;
  logic                   vis_q, vis_d, full_q, full_d, ovf_q, ovf_d, done_q, done_d;

  logic                   we;
  logic [AW-1:0]          waddr, raddr;
  logic [2*AB-1:0]        wdata, rdata;
  logic [AB-1:0]          rs, re, e1;
  logic [CW-1:0]          idx_inc, wr_inc, wr_n, spot_n;
  logic                   last, keep, have_n, c1, c2, hit, cov1_n, cov2_n;
  logic [CW+aics_pkg::CountOutW-1:0] count_ext;

  aics_mem #(
    .DEPTH(MAX_INTERVALS),
    .WIDTH(2 * AB)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign rs = rdata[2*AB-1:AB];
  assign re = rdata[AB-1:0];
  assign idx_inc = idx_q + ONE;
  assign wr_inc = wr_q + ONE;
  assign last = (idx_inc == count_q);
  assign keep = !((rs >= pa_q) && (re <= pb_q));
  assign wr_n = wr_q + {{(CW-1){1'b0}}, keep};
  assign have_n = have_q | (rs < pb_q);
  assign spot_n = (rs < pb_q) ? idx_q : spot_q;
  assign e1 = wrap_q ? AMAX : pb_q;
  assign c1 = (rs <= pa_q) && (re >= e1);
  assign c2 = (rs == '0) && (re >= pb_q);
  assign hit = (pa_q > rs) && (pa_q < re);
  assign cov1_n = cov1_q | ((mode_q == aics_pkg::MODE_ANGLE) ? hit : c1);
  assign cov2_n = cov2_q | c2;

  always_comb begin
    state_d = state_q;
    ph_d = ph_q;
    idx_d = idx_q;
    wr_d = wr_q;
    count_d = count_q;
    spot_d = spot_q;
    mode_d = mode_q;
    pa_d = pa_q;
    pb_d = pb_q;
    bsave_d = bsave_q;
    es_d = es_q;
    pend_d = pend_q;
    wrap_d = wrap_q;
    have_d = have_q;
    cov1_d = cov1_q;
    cov2_d = cov2_q;
    vis_d = vis_q;
    full_d = full_q;
    ovf_d = ovf_q;
    done_d = 1'b0;
    we = 1'b0;
    waddr = idx_q[AW-1:0];
    wdata = {pa_q, pb_q};
    raddr = idx_q[AW-1:0];
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          mode_d = mode_i;
          vis_d = 1'b0;
          ovf_d = 1'b0;
          pa_d = start_angle_i;
          pb_d = end_angle_i;
          bsave_d = end_angle_i;
          idx_d = '0;
          ph_d = 1'b0;
          pend_d = 1'b0;
          wrap_d = start_angle_i > end_angle_i;
          cov1_d = 1'b0;
          cov2_d = 1'b0;
          unique case (mode_i) inside
            aics_pkg::MODE_CLEAR: begin
              count_d = '0;
              state_d = S_FIN;
            end
            aics_pkg::MODE_ADD: begin
              if (start_angle_i > end_angle_i) begin
                pb_d = AMAX;
                pend_d = 1'b1;
              end
              state_d = S_PIECE;
            end
            aics_pkg::MODE_RANGE, aics_pkg::MODE_ANGLE: begin
              state_d = S_QRY;
            end
            default: begin
              state_d = S_FIN;
            end
          endcase
        end
      end
      S_PIECE: begin
        idx_d = '0;
        ph_d = 1'b0;
        if (count_q == '0) begin
          we = 1'b1;
          waddr = '0;
          count_d = ONE;
          state_d = S_NEXT;
        end else begin
          state_d = S_CONT;
        end
      end
      S_CONT: begin
        ph_d = !ph_q;
        if (ph_q) begin
          if ((rs <= pa_q) && (re >= pb_q)) begin
            state_d = S_NEXT;
          end else if (last) begin
            idx_d = '0;
            wr_d = '0;
            state_d = S_SWAL;
          end else begin
            idx_d = idx_inc;
          end
        end
      end
      S_SWAL: begin
        ph_d = !ph_q;
        if (ph_q) begin
          we = keep;
          waddr = wr_q[AW-1:0];
          wdata = rdata;
          wr_d = wr_n;
          idx_d = idx_inc;
          if (last) begin
            count_d = wr_n;
            idx_d = '0;
            have_d = 1'b0;
            spot_d = '0;
            state_d = (wr_n == '0) ? S_SHUP : S_MRG;
            wr_d = (wr_n == '0) ? '0 : wr_n;
          end
        end
      end
      S_MRG: begin
        ph_d = !ph_q;
        if (ph_q) begin
          have_d = have_n;
          spot_d = spot_n;
          if ((rs >= pa_q) && (rs <= pb_q)) begin
            we = 1'b1;
            wdata = {pa_q, re};
            state_d = S_NEXT;
          end else if ((re >= pa_q) && (re <= pb_q)) begin
            wr_d = idx_q;
            es_d = rs;
            if (idx_inc < count_q) begin
              state_d = S_NXT;
            end else begin
              we = 1'b1;
              wdata = {rs, pb_q};
              state_d = S_NEXT;
            end
          end else if (last) begin
            if (count_q >= CMAX) begin
              ovf_d = 1'b1;
              state_d = S_NEXT;
            end else begin
              wr_d = have_n ? (spot_n + ONE) : '0;
              idx_d = count_q;
              state_d = S_SHUP;
            end
          end else begin
            idx_d = idx_inc;
          end
        end
      end
      S_NXT: begin
        ph_d = !ph_q;
        raddr = wr_inc[AW-1:0];
        if (ph_q) begin
          we = 1'b1;
          waddr = wr_q[AW-1:0];
          if (rs <= pb_q) begin
            wdata = {es_q, re};
            idx_d = wr_inc;
            state_d = S_DROP;
          end else begin
            wdata = {es_q, pb_q};
            state_d = S_NEXT;
          end
        end
      end
      S_DROP: begin
        raddr = idx_inc[AW-1:0];
        if (!ph_q) begin
          if (idx_inc >= count_q) begin
            count_d = count_q - ONE;
            state_d = S_NEXT;
          end else begin
            ph_d = 1'b1;
          end
        end else begin
          we = 1'b1;
          wdata = rdata;
          idx_d = idx_inc;
          ph_d = 1'b0;
        end
      end
      S_SHUP: begin
        raddr = idx_q[AW-1:0] - AW'(1);
        if (!ph_q) begin
          if (idx_q == wr_q) begin
            we = 1'b1;
            count_d = count_q + ONE;
            state_d = S_NEXT;
          end else begin
            ph_d = 1'b1;
          end
        end else begin
          we = 1'b1;
          wdata = rdata;
          idx_d = idx_q - ONE;
          ph_d = 1'b0;
        end
      end
      S_NEXT: begin
        ph_d = 1'b0;
        if (pend_q) begin
          pend_d = 1'b0;
          pa_d = '0;
          pb_d = bsave_q;
          state_d = S_PIECE;
        end else begin
          state_d = S_FIN;
        end
      end
      S_QRY: begin
        if (!ph_q) begin
          if (count_q == '0) begin
            vis_d = 1'b1;
            state_d = S_FIN;
          end else begin
            ph_d = 1'b1;
          end
        end else begin
          ph_d = 1'b0;
          cov1_d = cov1_n;
          cov2_d = cov2_n;
          idx_d = idx_inc;
          if (last) begin
            if (mode_q == aics_pkg::MODE_ANGLE) begin
              vis_d = cd_q | !cov1_n;
            end else begin
              vis_d = cd_q | !cov1_n | (wrap_q & !cov2_n);
            end
            state_d = S_FIN;
          end
        end
      end
      S_FIN: begin
        raddr = '0;
        ph_d = !ph_q;
        if (ph_q) begin
          full_d = !cd_q && (count_q != '0) && (rs == '0) && (re == AMAX);
          done_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ph_q <= 1'b0;
      idx_q <= '0;
      wr_q <= '0;
      count_q <= '0;
      spot_q <= '0;
      cd_q <= 1'b0;
      mode_q <= '0;
      pa_q <= '0;
      pb_q <= '0;
      bsave_q <= '0;
      es_q <= '0;
      pend_q <= 1'b0;
      wrap_q <= 1'b0;
      have_q <= 1'b0;
      cov1_q <= 1'b0;
      cov2_q <= 1'b0;
      vis_q <= 1'b0;
      full_q <= 1'b0;
      ovf_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ph_q <= ph_d;
      idx_q <= idx_d;
      wr_q <= wr_d;
      count_q <= count_d;
      spot_q <= spot_d;
      if (cfg_we_i) begin
        cd_q <= cfg_wdata_i;
      end
      mode_q <= mode_d;
      pa_q <= pa_d;
      pb_q <= pb_d;
      bsave_q <= bsave_d;
      es_q <= es_d;
      pend_q <= pend_d;
      wrap_q <= wrap_d;
      have_q <= have_d;
      cov1_q <= cov1_d;
      cov2_q <= cov2_d;
      vis_q <= vis_d;
      full_q <= full_d;
      ovf_q <= ovf_d;
      done_q <= done_d;
    end
  end

  assign count_ext = {{aics_pkg::CountOutW{1'b0}}, count_q};
  assign busy = (state_q != S_IDLE);
  assign done_o = done_q;
  assign visible_o = vis_q;
  assign full_res_o = full_q;
  assign overflow_o = ovf_q;
  assign entry_count_o = count_ext[aics_pkg::CountOutW-1:0];

endmodule
`default_nettype wire

/* rtl/aics_checker.sv */
`default_nettype none
module aics_assert (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            start,
  input wire logic                            busy,
  input wire logic [aics_pkg::ModeW-1:0]      mode_i,
  input wire logic                            done_o,
  input wire logic                            visible_o,
  input wire logic                            overflow_o,
  input wire logic [aics_pkg::CountOutW-1:0]  entry_count_o
);

  logic [aics_pkg::ModeW-1:0] mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= '0;
    end else if (start && !busy) begin
      mode_q <= mode_i;
    end
  end

  // An accepted beat keeps the block occupied in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("busy not raised after accept");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result shown while busy");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");

  a_clear_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (mode_q == aics_pkg::MODE_CLEAR)) |->
      ((entry_count_o == '0) && !visible_o && !overflow_o))
    else $error("clear result wrong");

endmodule

bind angular_interval_coverage_set aics_assert u_aics_assert (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .mode_i       (mode_i),
  .done_o       (done_o),
  .visible_o    (visible_o),
  .overflow_o   (overflow_o),
  .entry_count_o(entry_count_o)
);
`default_nettype wire
